FILE: src/sch_pkg.sv
`default_nettype none
package sch_pkg;
   localparam int TABLE_SIZE = 1024;
   localparam int SLOT_W = $clog2(TABLE_SIZE);
   localparam int MAX_PROBES = 10;
   localparam int PROBE_W = $clog2(MAX_PROBES + 1);
   localparam int KEY_BYTES = 32;
   localparam int KEY_W = KEY_BYTES * 8;
   localparam int KLEN_W = 6;
   localparam int BCNT_W = $clog2(KEY_BYTES + 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_PURGE  = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_MISS   = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam logic [0:0] CSR_EXPIRE  = 1'd0;
   localparam logic [0:0] CSR_MAXLEN  = 1'd1;

   localparam logic [63:0] EXPIRE_RESET = 64'd300000000000;
   localparam logic [15:0] MAXLEN_RESET = 16'd10240;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HASH, ST_FINAL, ST_PREAD, ST_PWAIT, ST_PCHECK,
      ST_CLEAR, ST_ACT, ST_AWAIT, ST_ARESULT, ST_SREAD, ST_SWAIT, ST_SCHECK, ST_DONE,
      ST_INIT
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [KLEN_W-1:0] klen;
      logic [63:0]       created;
      logic [31:0]       handle;
      logic [15:0]       vlen;
   } entry_type;
endpackage
`default_nettype wire

FILE: src/session_cache_hash_table_core.sv
`default_nettype none
// Session cache: open-addressed hash table, linear probing, 1024 slots.
// Input channel: req_* fields, taken at a clock edge with start high and busy
// low. busy stays high until the result has been shown.
// Result channel: rsp_* fields, valid for one cycle while rsp_done is high.
// The receiver cannot stall; each result is shown exactly once.
// Configuration: csr_we with csr_index (0 expire_timeout, 1 max_value_len)
// and csr_wdata, to be written only while idle; the block does not enforce this.
// Sequence: a hash round per key byte through the shared adder, a finalize
// step, a read of each probed slot (up to 10, single read port), a clearing
// pass over an exhausted probe window, the action and then the result. The
// next transaction can be taken in the cycle after the result. Purge sweeps
// every slot, reading each and clearing its valid bit if the entry expired.
// A rejected insert shows its result in the cycle after acceptance.
// Reset restores the configuration defaults, then clears the slot valid bits
// in a pass over all 1024 slots with busy high; the slot payload memory is not cleared.
module session_cache_hash_table_core
   import sch_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [63:0] req_key_word0,
   input  wire logic [63:0] req_key_word1,
   input  wire logic [63:0] req_key_word2,
   input  wire logic [63:0] req_key_word3,
   input  wire logic [5:0]  req_key_len,
   input  wire logic [31:0] req_value_handle,
   input  wire logic [15:0] req_value_len,
   input  wire logic [63:0] req_now_time,
   output logic             rsp_done,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_found_handle,
   output logic [15:0]      rsp_found_len,
   output logic [9:0]       rsp_slot_index,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   state_type state_ff, state_in;

   logic [63:0]       expire_ff;
   logic [15:0]       maxlen_ff;
   logic [1:0]        mode_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  key_orig_ff;
   logic [KLEN_W-1:0] klen_ff;
   logic [31:0]       handle_ff;
   logic [15:0]       vlen_ff;
   logic [63:0]       now_ff;
   logic [63:0]       edge_ff;
   logic [31:0]       hash_ff, hash_in;
   logic [BCNT_W-1:0] bcnt_ff;
   logic [SLOT_W-1:0] start_slot_ff, idx_ff;
   logic [PROBE_W-1:0] pcnt_ff;
   logic [1:0]        hstep_ff;
   logic              vmem [TABLE_SIZE];
   logic              rd_valid_ff;
   logic              vmem_we, vmem_wd;
   entry_type         mem [TABLE_SIZE];
   entry_type         rd_ff;
   logic [1:0]        status_ff;
   logic [31:0]       fh_ff;
   logic [15:0]       fl_ff;
   logic [SLOT_W-1:0] si_ff;
   logic [31:0]       add_a, add_b, add_sum;
   logic [KLEN_W-1:0] len_clip;
   logic [KEY_W-1:0]  key_raw, key_mask;
   logic [7:0]        cur_byte;
   logic              slot_v, expired, key_hit;

   // Shared 32-bit adder for hash rounds
   assign add_sum = add_a + add_b;

   assign len_clip = (req_key_len > KLEN_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES) : req_key_len;

   assign key_raw = {req_key_word3, req_key_word2, req_key_word1, req_key_word0};
   always_comb begin
      for (int b = 0; b < KEY_BYTES; b++)
         key_mask[b*8 +: 8] = (b < int'(len_clip)) ? 8'hFF : 8'h00;
   end

   assign cur_byte = key_ff[7:0];

   assign slot_v  = rd_valid_ff;
   assign expired = rd_ff.created < edge_ff;
   assign key_hit = (rd_ff.klen == klen_ff) && (rd_ff.key == key_ff);

   // Hash datapath: hash rounds and finalize, each in three substeps sharing one adder
   always_comb begin
      add_a = hash_ff;
      add_b = 32'd0;
      hash_in = hash_ff;
      if (state_ff == ST_HASH) begin
         case (hstep_ff)
            2'd0: begin add_b = {24'd0, cur_byte}; hash_in = add_sum; end
            2'd1: begin add_b = hash_ff << 10; hash_in = add_sum; end
            default: hash_in = hash_ff ^ (hash_ff >> 6);
         endcase
      end else if (state_ff == ST_FINAL) begin
         case (hstep_ff)
            2'd0: begin add_b = hash_ff << 3; hash_in = add_sum; end
            2'd1: hash_in = hash_ff ^ (hash_ff >> 11);
            default: begin add_b = hash_ff << 15; hash_in = add_sum; end
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: if (idx_ff == SLOT_W'(TABLE_SIZE - 1)) state_in = ST_IDLE;
         ST_IDLE: if (start) begin
            if (req_mode == MODE_PURGE) state_in = ST_SREAD;
            else if (req_mode == MODE_INSERT && req_value_len > maxlen_ff) state_in = ST_DONE;
            else if (len_clip == '0) state_in = ST_FINAL;
            else state_in = ST_HASH;
         end
         ST_HASH: if (hstep_ff == 2'd2 && bcnt_ff == BCNT_W'(1)) state_in = ST_FINAL;
         ST_FINAL: if (hstep_ff == 2'd2) state_in = ST_PREAD;
         ST_PREAD: state_in = ST_PWAIT;
         ST_PWAIT: state_in = ST_PCHECK;
         ST_PCHECK: begin
            if (!slot_v || (!expired && key_hit)) state_in = ST_ACT;
            else if (pcnt_ff == PROBE_W'(MAX_PROBES - 1)) state_in = ST_CLEAR;
            else state_in = ST_PREAD;
         end
         ST_CLEAR: if (pcnt_ff == PROBE_W'(MAX_PROBES - 1)) state_in = ST_ACT;
         ST_ACT: state_in = ST_AWAIT;
         ST_AWAIT: state_in = ST_ARESULT;
         ST_ARESULT: state_in = ST_DONE;
         ST_SREAD: state_in = ST_SWAIT;
         ST_SWAIT: state_in = ST_SCHECK;
         ST_SCHECK: state_in = (idx_ff == SLOT_W'(TABLE_SIZE - 1)) ? ST_DONE : ST_SREAD;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      busy = (state_ff != ST_IDLE);
      rsp_done = (state_ff == ST_DONE);
      rsp_status = status_ff;
      rsp_found_handle = fh_ff;
      rsp_found_len = fl_ff;
      rsp_slot_index = 10'(si_ff);
   end

   // Valid bit write at the current slot
   always_comb begin
      vmem_we = 1'b0;
      vmem_wd = 1'b0;
      case (state_ff)
         ST_INIT: vmem_we = 1'b1;
         ST_PCHECK: vmem_we = slot_v && expired;
         ST_CLEAR: vmem_we = 1'b1;
         ST_ACT: begin
            vmem_we = (mode_ff == MODE_INSERT) || (mode_ff == MODE_REMOVE);
            vmem_wd = (mode_ff == MODE_INSERT);
         end
         ST_SCHECK: vmem_we = slot_v && expired;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         expire_ff <= EXPIRE_RESET;
         maxlen_ff <= MAXLEN_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_EXPIRE: expire_ff <= csr_wdata;
               CSR_MAXLEN: maxlen_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // Valid memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (vmem_we)
         vmem[idx_ff] <= vmem_wd;
      if (state_ff == ST_PREAD || state_ff == ST_SREAD || state_ff == ST_AWAIT)
         rd_valid_ff <= vmem[idx_ff];
   end

   // Slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_ACT && mode_ff == MODE_INSERT)
         mem[idx_ff] <= '{key: key_orig_ff, klen: klen_ff, created: now_ff,
                          handle: handle_ff, vlen: vlen_ff};
      if (state_ff == ST_PREAD || state_ff == ST_SREAD || state_ff == ST_AWAIT)
         rd_ff <= mem[idx_ff];
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         case (state_ff)
            ST_INIT: idx_ff <= idx_ff + SLOT_W'(1);
            ST_IDLE: if (start) begin
               mode_ff <= req_mode;
               key_ff <= key_raw & key_mask;
               key_orig_ff <= key_raw & key_mask;
               klen_ff <= len_clip;
               bcnt_ff <= BCNT_W'(len_clip);
               handle_ff <= req_value_handle;
               vlen_ff <= req_value_len;
               now_ff <= req_now_time;
               edge_ff <= req_now_time - expire_ff;
               hash_ff <= '0;
               hstep_ff <= '0;
               idx_ff <= '0;
               status_ff <= (req_mode == MODE_INSERT && req_value_len > maxlen_ff) ?
                            STATUS_REJECT : STATUS_OK;
               fh_ff <= '0;
               fl_ff <= '0;
               si_ff <= '0;
            end
            ST_HASH: begin
               hash_ff <= hash_in;
               hstep_ff <= (hstep_ff == 2'd2) ? 2'd0 : hstep_ff + 2'd1;
               if (hstep_ff == 2'd2) begin
                  key_ff <= key_ff >> 8;
                  bcnt_ff <= bcnt_ff - BCNT_W'(1);
               end
            end
            ST_FINAL: begin
               hash_ff <= hash_in;
               hstep_ff <= (hstep_ff == 2'd2) ? 2'd0 : hstep_ff + 2'd1;
               if (hstep_ff == 2'd2) begin
                  start_slot_ff <= hash_in[SLOT_W-1:0];
                  idx_ff <= hash_in[SLOT_W-1:0];
                  pcnt_ff <= '0;
                  key_ff <= key_orig_ff;
               end
            end
            ST_PCHECK: begin
               if (!slot_v || (!expired && key_hit)) ;
               else if (pcnt_ff == PROBE_W'(MAX_PROBES - 1)) begin
                  idx_ff <= start_slot_ff;
                  pcnt_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + SLOT_W'(1);
                  pcnt_ff <= pcnt_ff + PROBE_W'(1);
               end
            end
            ST_CLEAR: begin
               if (pcnt_ff == PROBE_W'(MAX_PROBES - 1)) idx_ff <= start_slot_ff;
               else idx_ff <= idx_ff + SLOT_W'(1);
               pcnt_ff <= pcnt_ff + PROBE_W'(1);
            end
            ST_ACT: si_ff <= idx_ff;
            ST_ARESULT: begin
               if (mode_ff == MODE_LOOKUP) begin
                  if (slot_v) begin
                     fh_ff <= rd_ff.handle;
                     fl_ff <= rd_ff.vlen;
                  end else status_ff <= STATUS_MISS;
               end
            end
            ST_SCHECK: idx_ff <= idx_ff + SLOT_W'(1);
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: src/sch_checker.sv
`default_nettype none
module sch_checker
   import sch_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_done,
   input wire logic [1:0] rsp_status,
   input wire logic [31:0] rsp_found_handle,
   input wire logic [9:0] rsp_slot_index
);
   // Accepted transaction makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   // Result strobe lasts one cycle
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_done |=> !rsp_done) else $error("result strobe too long");
   // Result only while busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_done |-> busy) else $error("result while idle");
   // A miss or reject carries no handle
   a_nohandle: assert property (@(posedge clock) disable iff (reset)
      (rsp_done && rsp_status != STATUS_OK) |-> rsp_found_handle == 32'd0)
      else $error("handle on miss");
   // A rejected insert picks no slot
   a_reject_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_done && rsp_status == STATUS_REJECT) |-> rsp_slot_index == 10'd0)
      else $error("slot on reject");
endmodule

bind session_cache_hash_table_core sch_checker u_sch_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_done(rsp_done), .rsp_status(rsp_status), .rsp_found_handle(rsp_found_handle),
   .rsp_slot_index(rsp_slot_index)
);
`default_nettype wire
